// File: rtl/core/bba_pkg.sv
// Shared types, constants and codes of the buddy block allocator.
package bba_pkg;

  localparam int UNIT_COUNT   = 4096;
  localparam int ORDER_LEVELS = 11;
  localparam int TOP_ORDER    = ORDER_LEVELS - 1;
  localparam int IDX_W        = 12;
  localparam int LINK_W       = 13;
  localparam int ORD_W        = 4;
  localparam int SIZE_W       = 17;

  localparam logic [LINK_W-1:0] NIL       = LINK_W'(UNIT_COUNT);
  localparam logic [LINK_W-1:0] COUNT_MAX = '1;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_NOBLK = 2'd1;
  localparam logic [1:0] STATUS_BAD   = 2'd2;

  typedef struct packed {
    logic             cmd;
    logic [ORD_W-1:0] block_order;
    logic [IDX_W-1:0] unit_index;
  } bba_in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] granted_index;
  } bba_out_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_CLEAR, OP_ASEL, OP_REM, OP_SPLIT,
    OP_PUSH1, OP_PUSH2, OP_FRD, OP_RESULT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       merge;
    logic [1:0] status;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic is_alloc;
    logic order_bad;
    logic free_bad;
    logic any_found;
    logic cur_gt_ord;
    logic cur_at_top;
    logic head_valid;
    logic buddy_match;
    logic out_busy;
  } dp_stat_t;

endpackage

// File: rtl/core/buddy_block_allocator.sv
// Top level of the buddy block allocator.
// One request is handled at a time. After reset the unit table is cleared entry by entry
// and no request is taken. Each merge level of a free costs one registered read of the
// link and unit memories and one write step. Each split level of an allocate costs one
// step and one to two write steps. A result waits in an output register while the next
// request is taken, and a stalled result holds the next one back.
module buddy_block_allocator import bba_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  bba_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output bba_out_t out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  bba_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// File: rtl/core/bba_datapath.sv
// Datapath of the buddy allocator: link and unit memories, list heads and result register.
module bba_datapath import bba_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  bba_in_t  in_data,
  output bba_out_t out_data,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat
);

  logic [LINK_W-1:0] nxt_mem [UNIT_COUNT];
  logic [LINK_W-1:0] prv_mem [UNIT_COUNT];
  logic [ORD_W:0]    meta_mem [UNIT_COUNT];

  logic [LINK_W-1:0] nxt_q, prv_q;
  logic [ORD_W:0]    meta_q;

  logic              is_alloc_r;
  logic [ORD_W-1:0]  ord_r, cur_r;
  logic [IDX_W-1:0]  blk_r, grant_r, rem_r, clr_r;
  logic [LINK_W-1:0] hprev_r;
  logic [LINK_W-1:0] head_r [ORDER_LEVELS];
  logic [LINK_W-1:0] cnt_r [ORDER_LEVELS];
  bba_out_t          out_r;
  logic              out_valid_r;

  logic              any_found;
  logic [ORD_W-1:0]  found_ord;
  logic [LINK_W-1:0] cur_head;
  logic [IDX_W-1:0]  cur_bit, buddy, half, raddr;
  logic [SIZE_W-1:0] size_w, blk_w;

  logic              nxt_we, prv_we, meta_we;
  logic [IDX_W-1:0]  nxt_wa, prv_wa, meta_wa;
  logic [LINK_W-1:0] nxt_wd, prv_wd;
  logic [ORD_W:0]    meta_wd;

  always_comb begin
    any_found = 1'b0;
    found_ord = '0;
    for (int i = TOP_ORDER; i >= 0; i--) begin
      if (ORD_W'(i) >= ord_r && head_r[i] < NIL) begin
        any_found = 1'b1;
        found_ord = ORD_W'(i);
      end
    end
  end

  assign cur_head = (cur_r <= ORD_W'(TOP_ORDER)) ? head_r[cur_r] : NIL;
  assign cur_bit  = IDX_W'(1) << cur_r;
  assign buddy    = blk_r ^ cur_bit;
  assign half     = grant_r + (IDX_W'(1) << (cur_r - ORD_W'(1)));
  assign size_w   = SIZE_W'(1) << ord_r;
  assign blk_w    = SIZE_W'(blk_r);
  assign raddr    = (cmd.op == OP_ASEL) ? head_r[found_ord][IDX_W-1:0] : buddy;

  assign stat.clear_last  = (clr_r == IDX_W'(UNIT_COUNT - 1));
  assign stat.is_alloc    = is_alloc_r;
  assign stat.order_bad   = (ord_r > ORD_W'(TOP_ORDER));
  assign stat.free_bad    = ((blk_w & (size_w - SIZE_W'(1))) != '0) ||
                            ((blk_w + size_w) > SIZE_W'(UNIT_COUNT));
  assign stat.any_found   = any_found;
  assign stat.cur_gt_ord  = (cur_r > ord_r);
  assign stat.cur_at_top  = (cur_r == ORD_W'(TOP_ORDER));
  assign stat.head_valid  = (cur_head < NIL);
  assign stat.buddy_match = meta_q[ORD_W] && (meta_q[ORD_W-1:0] == cur_r);
  assign stat.out_busy    = out_valid_r && out_stall;

  always_comb begin
    nxt_we  = 1'b0;
    nxt_wa  = blk_r;
    nxt_wd  = cur_head;
    prv_we  = 1'b0;
    prv_wa  = blk_r;
    prv_wd  = NIL;
    meta_we = 1'b0;
    meta_wa = blk_r;
    meta_wd = {1'b1, cur_r};
    case (cmd.op)
      OP_CLEAR: begin
        meta_we = 1'b1;
        meta_wa = clr_r;
        meta_wd = '0;
      end
      OP_REM: begin
        nxt_we  = (prv_q < NIL);
        nxt_wa  = prv_q[IDX_W-1:0];
        nxt_wd  = nxt_q;
        prv_we  = (nxt_q < NIL);
        prv_wa  = nxt_q[IDX_W-1:0];
        prv_wd  = prv_q;
        meta_we = 1'b1;
        meta_wa = rem_r;
        meta_wd = '0;
      end
      OP_PUSH1: begin
        nxt_we  = 1'b1;
        prv_we  = 1'b1;
        meta_we = 1'b1;
      end
      OP_PUSH2: begin
        prv_we = 1'b1;
        prv_wa = hprev_r[IDX_W-1:0];
        prv_wd = LINK_W'(blk_r);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (nxt_we) begin
      nxt_mem[nxt_wa] <= nxt_wd;
    end
    if (prv_we) begin
      prv_mem[prv_wa] <= prv_wd;
    end
    if (meta_we) begin
      meta_mem[meta_wa] <= meta_wd;
    end
    nxt_q  <= nxt_mem[raddr];
    prv_q  <= prv_mem[raddr];
    meta_q <= meta_mem[raddr];
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        is_alloc_r <= (in_data.cmd == CMD_ALLOC);
        ord_r      <= in_data.block_order;
        cur_r      <= in_data.block_order;
        blk_r      <= in_data.unit_index;
      end
      OP_ASEL: begin
        cur_r   <= found_ord;
        grant_r <= head_r[found_ord][IDX_W-1:0];
        rem_r   <= head_r[found_ord][IDX_W-1:0];
      end
      OP_REM: begin
        if (cmd.merge) begin
          blk_r <= blk_r & ~cur_bit;
          cur_r <= cur_r + ORD_W'(1);
        end
      end
      OP_SPLIT: begin
        cur_r <= cur_r - ORD_W'(1);
        blk_r <= half;
      end
      OP_PUSH1: begin
        hprev_r <= cur_head;
      end
      OP_FRD: begin
        rem_r <= buddy;
      end
      OP_RESULT: begin
        out_r.status        <= cmd.status;
        out_r.granted_index <= (cmd.status == STATUS_OK && is_alloc_r) ? grant_r : '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      clr_r       <= '0;
      for (int i = 0; i < ORDER_LEVELS; i++) begin
        head_r[i] <= NIL;
        cnt_r[i]  <= '0;
      end
    end else begin
      if (cmd.op == OP_RESULT) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.op == OP_CLEAR) begin
        clr_r <= clr_r + IDX_W'(1);
      end
      if (cmd.op == OP_REM) begin
        if (prv_q >= NIL) begin
          head_r[cur_r] <= nxt_q;
        end
        if (cnt_r[cur_r] != '0) begin
          cnt_r[cur_r] <= cnt_r[cur_r] - LINK_W'(1);
        end
      end
      if (cmd.op == OP_PUSH1) begin
        head_r[cur_r] <= LINK_W'(blk_r);
        if (cnt_r[cur_r] < COUNT_MAX) begin
          cnt_r[cur_r] <= cnt_r[cur_r] + LINK_W'(1);
        end
      end
    end
  end

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_RESULT |-> !(out_valid_r && out_stall))
    else $error("Result loaded over a pending transfer.");
  a_zero_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status != STATUS_OK |-> out_r.granted_index == '0)
    else $error("Nonzero index on a failed request.");
  a_push_pair: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_PUSH2 |-> $past(cmd.op) == OP_PUSH1)
    else $error("Second push step without a first.");
`endif

endmodule

// File: rtl/core/bba_ctrl.sv
// Controller state machine of the buddy allocator.
module bba_ctrl import bba_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_CHK, S_AREM, S_SPLIT, S_FWALK, S_FEVAL,
    S_PUSH1, S_PUSH2, S_DONE
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] status_r, status_nxt;
  state_t     post_push;

  assign post_push = (stat.is_alloc && stat.cur_gt_ord) ? S_SPLIT : S_DONE;

  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    cmd.op     = OP_NONE;
    cmd.merge  = 1'b0;
    cmd.status = status_r;
    unique case (state_r)
      S_CLR: begin
        cmd.op = OP_CLEAR;
        if (stat.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (stat.order_bad) begin
          status_nxt = STATUS_BAD;
          state_nxt  = S_DONE;
        end else if (stat.is_alloc) begin
          if (stat.any_found) begin
            cmd.op     = OP_ASEL;
            status_nxt = STATUS_OK;
            state_nxt  = S_AREM;
          end else begin
            status_nxt = STATUS_NOBLK;
            state_nxt  = S_DONE;
          end
        end else if (stat.free_bad) begin
          status_nxt = STATUS_BAD;
          state_nxt  = S_DONE;
        end else begin
          status_nxt = STATUS_OK;
          state_nxt  = S_FWALK;
        end
      end
      S_AREM: begin
        cmd.op    = OP_REM;
        state_nxt = stat.cur_gt_ord ? S_SPLIT : S_DONE;
      end
      S_SPLIT: begin
        cmd.op    = OP_SPLIT;
        state_nxt = S_PUSH1;
      end
      S_FWALK: begin
        if (stat.cur_at_top) begin
          state_nxt = S_PUSH1;
        end else begin
          cmd.op    = OP_FRD;
          state_nxt = S_FEVAL;
        end
      end
      S_FEVAL: begin
        if (stat.buddy_match) begin
          cmd.op    = OP_REM;
          cmd.merge = 1'b1;
          state_nxt = S_FWALK;
        end else begin
          state_nxt = S_PUSH1;
        end
      end
      S_PUSH1: begin
        cmd.op    = OP_PUSH1;
        state_nxt = stat.head_valid ? S_PUSH2 : post_push;
      end
      S_PUSH2: begin
        cmd.op    = OP_PUSH2;
        state_nxt = post_push;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.op    = OP_RESULT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      status_r <= STATUS_OK;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

`ifndef SYNTHESIS
  a_load_on_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_LOAD |=> state_r == S_CHK)
    else $error("Accepted transfer not checked.");
  a_merge_walks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_REM && cmd.merge |=> state_r == S_FWALK)
    else $error("Merge not followed by the next level.");
  a_result_idles: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_RESULT |=> !in_stall)
    else $error("Not ready after a result.");
`endif

endmodule
